>>> rtl/cfra_pkg.sv
// Package for the continued-fraction rational approximator.
// Holds field widths, bounds, default parameter values and the control/status structs.
// No dependencies.
package cfra_pkg;

  localparam int unsigned VAL_W = 64;
  localparam int unsigned NUM_W = 50;
  localparam int unsigned DEN_W = 32;

  localparam int unsigned ITER_LIMIT_DEF = 20;
  localparam int unsigned FRAC_BITS_DEF  = 32;

  // Largest numerator that may appear in a returned convergent.
  localparam logic [NUM_W-1:0] NUM_BOUND     = 50'd1_000_000_000_000_000;
  localparam logic [DEN_W-1:0] MAX_DEN_RESET = 32'd1_000_000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture a new item
    logic start_div;  // prime divider and quotient accumulators
    logic div_step;   // one quotient bit
    logic commit;     // take the new convergent if it is in bounds
    logic finish;     // move the convergent to the output register
  } cfra_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rnum_zero;  // remainder numerator is zero
    logic q_over;     // current denominator above the limit
    logic bound_ok;   // next convergent stays within both bounds
    logic out_busy;   // output register holds an item not taken this cycle
  } cfra_sts_t;

endpackage

>>> rtl/cfra_ifs.sv
// Valid/ready channel interfaces for the approximator's input and output items.
// Depends on cfra_pkg for the field widths.
interface cfra_in_if;
  logic                            valid;
  logic                            ready;
  logic [cfra_pkg::VAL_W-1:0]      value_fixed;

  modport source (output valid, output value_fixed, input ready);
  modport sink   (input valid, input value_fixed, output ready);
endinterface

interface cfra_out_if;
  logic                            valid;
  logic                            ready;
  logic [cfra_pkg::NUM_W-1:0]      numerator;
  logic [cfra_pkg::DEN_W-1:0]      denominator;

  modport source (output valid, output numerator, output denominator, input ready);
  modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

>>> rtl/cfra_ctrl.sv
// Sequencer for the approximator: runs the Euclid iterations and the bit-serial divide.
// Depends on cfra_pkg for the command and status structs.
module cfra_ctrl #(
  parameter int unsigned ITER_LIMIT = cfra_pkg::ITER_LIMIT_DEF,
  parameter int unsigned FRAC_BITS  = cfra_pkg::FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cfra_pkg::cfra_sts_t sts_i,
  output cfra_pkg::cfra_cmd_t cmd_o
);
  import cfra_pkg::*;

  localparam int unsigned DW = FRAC_BITS + 1;
  localparam int unsigned CW = $clog2(DW);
  localparam int unsigned IW = $clog2(ITER_LIMIT + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_UPDATE = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [IW-1:0] iter_q, iter_d;
  logic [CW-1:0] bit_q, bit_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    bit_d   = bit_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          iter_d     = '0;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (iter_q == IW'(ITER_LIMIT) || sts_i.rnum_zero || sts_i.q_over) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.start_div = 1'b1;
          bit_d           = '0;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        bit_d          = bit_q + 1'b1;
        if (bit_q == CW'(DW - 1)) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd_o.commit = 1'b1;
        if (sts_i.bound_ok) begin
          iter_d  = iter_q + 1'b1;
          state_d = S_CHECK;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      iter_q  <= '0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
      bit_q   <= bit_d;
    end
  end

endmodule

>>> rtl/cfra_dp.sv
// Datapath: convergent registers, restoring divider, Horner quotient multiply, output register.
// Depends on cfra_pkg for widths, bounds and the command and status structs.
module cfra_dp #(
  parameter int unsigned FRAC_BITS = cfra_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfra_pkg::cfra_cmd_t           cmd_i,
  output cfra_pkg::cfra_sts_t           sts_o,
  input  logic [cfra_pkg::VAL_W-1:0]    value_fixed_i,
  input  logic [cfra_pkg::DEN_W-1:0]    max_den_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [cfra_pkg::NUM_W-1:0]    numerator_o,
  output logic [cfra_pkg::DEN_W-1:0]    denominator_o
);
  import cfra_pkg::*;

  localparam int unsigned DW = FRAC_BITS + 1;

  // Convergent pairs
  logic [NUM_W-1:0] p_prev_q, p_cur_q;
  logic [DEN_W-1:0] q_prev_q, q_cur_q;
  // Rational remainder r_num / r_den
  logic [DW-1:0]        r_den_q;
  logic [FRAC_BITS-1:0] r_num_q;
  // Divider
  logic [DW-1:0] div_n_q, div_r_q;
  // Quotient times current convergent, with sticky overflow
  logic [NUM_W+1:0] acc_p_q;
  logic [DEN_W+1:0] acc_q_q;
  logic             ov_p_q, ov_q_q;
  // Output register
  logic             out_valid_q;
  logic [NUM_W-1:0] out_num_q;
  logic [DEN_W-1:0] out_den_q;

  logic [VAL_W-1:0] whole;
  logic [NUM_W-1:0] whole_sat;
  logic [DW-1:0]    rem_sh, d_ext, rem_nx;
  logic             qbit;
  logic [NUM_W+1:0] tp;
  logic [DEN_W+1:0] tq;
  logic [NUM_W:0]   p_sum;
  logic [DEN_W:0]   q_sum;

  assign whole     = value_fixed_i >> FRAC_BITS;
  assign whole_sat = (whole > VAL_W'(NUM_BOUND)) ? NUM_BOUND : whole[NUM_W-1:0];

  // One restoring-division step, quotient bits MSB first.
  assign rem_sh = {div_r_q[DW-2:0], div_n_q[DW-1]};
  assign d_ext  = {1'b0, r_num_q};
  assign qbit   = (rem_sh >= d_ext);
  assign rem_nx = qbit ? (rem_sh - d_ext) : rem_sh;

  // Horner: acc = 2*acc + qbit*cur. Once over the bound it only grows, so flag and hold.
  assign tp = {acc_p_q[NUM_W:0], 1'b0} + (qbit ? {2'b00, p_cur_q} : '0);
  assign tq = {acc_q_q[DEN_W:0], 1'b0} + (qbit ? {2'b00, q_cur_q} : '0);

  assign p_sum = {1'b0, acc_p_q[NUM_W-1:0]} + {1'b0, p_prev_q};
  assign q_sum = {1'b0, acc_q_q[DEN_W-1:0]} + {1'b0, q_prev_q};

  assign sts_o.rnum_zero = (r_num_q == '0);
  assign sts_o.q_over    = (q_cur_q > max_den_i);
  assign sts_o.bound_ok  = !ov_p_q && !ov_q_q &&
                           (p_sum <= {1'b0, NUM_BOUND}) && (q_sum <= {1'b0, max_den_i});
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      p_prev_q <= NUM_W'(1);
      p_cur_q  <= whole_sat;
      q_prev_q <= '0;
      q_cur_q  <= DEN_W'(1);
      r_den_q  <= DW'(1) << FRAC_BITS;
      r_num_q  <= value_fixed_i[FRAC_BITS-1:0];
    end
    if (cmd_i.start_div) begin
      div_n_q <= r_den_q;
      div_r_q <= '0;
      acc_p_q <= '0;
      acc_q_q <= '0;
      ov_p_q  <= 1'b0;
      ov_q_q  <= 1'b0;
    end
    if (cmd_i.div_step) begin
      div_n_q <= {div_n_q[DW-2:0], 1'b0};
      div_r_q <= rem_nx;
      if (!ov_p_q) begin
        acc_p_q <= tp;
        ov_p_q  <= (tp > (NUM_W+2)'(NUM_BOUND));
      end
      if (!ov_q_q) begin
        acc_q_q <= tq;
        ov_q_q  <= (tq > {2'b00, max_den_i});
      end
    end
    if (cmd_i.commit) begin
      r_den_q <= d_ext;
      r_num_q <= div_r_q[FRAC_BITS-1:0];
      if (sts_o.bound_ok) begin
        p_prev_q <= p_cur_q;
        p_cur_q  <= p_sum[NUM_W-1:0];
        q_prev_q <= q_cur_q;
        q_cur_q  <= q_sum[DEN_W-1:0];
      end
    end
    if (cmd_i.finish) begin
      out_num_q <= p_cur_q;
      out_den_q <= q_cur_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign numerator_o   = out_num_q;
  assign denominator_o = out_den_q;

endmodule

>>> rtl/continued_fraction_rational_approx.sv
// Continued-fraction rational approximator, top level.
// Input item: value_fixed, an unsigned fixed-point value with FRAC_BITS fraction bits.
// Output item: numerator / denominator, the last convergent of its continued fraction
// that keeps the numerator at most 1e15 and the denominator at most max_denominator.
// Channels: in_i and out_o are valid/ready; an item moves when both are high at a
// clock edge. Configuration: cfg_we_i writes cfg_wdata_i into max_denominator
// (reset value 1000000); write it only while the block is idle.
// Sequence: the accept, then for each Euclid step a check, the restoring divider that
// works one quotient bit per cycle and also multiplies the quotient into both
// convergents, and a commit; then a final check and a handoff. A value with no
// fraction bits goes from the first check straight to the handoff. The divider sets
// the pace; one item is worked at a time and in_i.ready is high only while the
// sequencer is idle.
// The result goes into an output register, so the next item is taken while a
// finished result waits; if out_o stalls, a second finished result waits in the
// sequencer until the register frees up, and the input stays closed meanwhile.
// Reset clears the sequencer and the output valid and restores max_denominator.
module continued_fraction_rational_approx #(
  parameter int unsigned ITER_LIMIT = cfra_pkg::ITER_LIMIT_DEF,
  parameter int unsigned FRAC_BITS  = cfra_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [cfra_pkg::DEN_W-1:0] cfg_wdata_i,
  cfra_in_if.sink                    in_i,
  cfra_out_if.source                 out_o
);
  import cfra_pkg::*;

  cfra_cmd_t        cmd;
  cfra_sts_t        sts;
  logic [DEN_W-1:0] max_den_q;

  // Denominator limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_den_q <= MAX_DEN_RESET;
    end else if (cfg_we_i) begin
      max_den_q <= cfg_wdata_i;
    end
  end

  // Sequencer: accept, iterate, hand off.
  cfra_ctrl #(
    .ITER_LIMIT (ITER_LIMIT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Euclid divider, convergent update and output register.
  cfra_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .value_fixed_i (in_i.value_fixed),
    .max_den_i     (max_den_q),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .numerator_o   (out_o.numerator),
    .denominator_o (out_o.denominator)
  );

endmodule

>>> rtl/cfra_checker.sv
// Port-level checks for the approximator, bound to the top level.
// Depends on cfra_pkg for widths and the numerator bound.
module cfra_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [cfra_pkg::NUM_W-1:0] numerator_i,
  input logic [cfra_pkg::DEN_W-1:0] denominator_i
);
  import cfra_pkg::*;

  // A result never carries a zero denominator.
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (denominator_i != '0))
    else $error("denominator is zero");

  // A result never carries a numerator above the bound.
  a_num_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (numerator_i <= NUM_BOUND))
    else $error("numerator above bound");

  // The block works one item at a time: input closes right after an accept.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input accepted back to back");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(numerator_i) && $stable(denominator_i)))
    else $error("stalled result changed");

endmodule

bind continued_fraction_rational_approx cfra_checker u_cfra_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .numerator_i   (out_o.numerator),
  .denominator_i (out_o.denominator)
);
